### design/gldp_pkg.sv
package gldp_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;

  localparam int ROW_BITS       = 12;
  localparam int COL_OUT_BITS   = 10;
  localparam int INDEX_BITS     = 16;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  localparam int RESET_WIDTH    = 20;
  localparam int RESET_HEIGHT   = 20;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic col_first;
    logic col_ge2;
    logic last_col;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
  } pos_flags_t;

endpackage

### design/grid_local_peak_detect_core.sv
// Four-neighbor local peak finder over a raster pixel stream. One pixel is
// taken per clock while in_stall is low; it waits in the decision register,
// where its line-store reads and neighbor compares are resolved; its peaks
// then go to the result registers. A pixel in a non-final row is decided
// when the pixel below it arrives; in the final row a pixel is decided when
// its right neighbor arrives, so one pixel can release up to three peaks,
// the last of them marked by last_of_run. While out_stall is low, results
// leave one per clock through the single result port and pixels are taken
// one per clock, but a pixel that releases two or three peaks holds the
// input until all but its last peak have left. Writing frame_width or
// frame_height restarts the frame; width is clamped to 1..MAX_WIDTH and
// height to 1..4096. The line store needs no clearing pass after reset.
module grid_local_peak_detect_core import gldp_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIXEL_BITS-1:0]     pixel_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIXEL_BITS-1:0]     peak_value,
  output logic [ROW_BITS-1:0]       peak_row,
  output logic [COL_OUT_BITS-1:0]   peak_column,
  output logic [INDEX_BITS-1:0]     peak_index,
  output logic                      last_of_run
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                  in_accept;
  logic                  restart;
  logic [ROW_BITS-1:0]   row;
  logic [COL_W-1:0]      col;
  pos_flags_t            flags;
  logic [COL_W-1:0]      addr_b;

  logic                  s1_vld;
  logic                  s1_go;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [ROW_BITS-1:0]   s1_row;
  logic [COL_W-1:0]      s1_col;
  pos_flags_t            s1_flags;

  logic                  fw_a;
  logic                  fw_b;
  logic [PIXEL_BITS-1:0] fw_prev;
  logic [PIXEL_BITS-1:0] fw_old;

  logic [2*PIXEL_BITS-1:0] q_a;
  logic [2*PIXEL_BITS-1:0] q_b;
  logic [PIXEL_BITS-1:0]   a_eff;
  logic [PIXEL_BITS-1:0]   up_eff;
  logic [PIXEL_BITS-1:0]   rt_eff;

  logic [PIXEL_BITS-1:0] recent_above;
  logic [PIXEL_BITS-1:0] recent_pix;
  logic [PIXEL_BITS-1:0] two_back;

  assign in_stall  = s1_vld && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign addr_b    = flags.last_col ? col : col + 1'b1;

  gldp_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_accept),
    .restart   (restart),
    .row       (row),
    .col       (col),
    .flags     (flags)
  );

  gldp_ram #(
    .WIDTH (2*PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .we      (s1_go),
    .waddr   (s1_col),
    .wdata   ({a_eff, s1_pix}),
    .re      (in_accept),
    .raddr_a (col),
    .raddr_b (addr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  // forward the departing pixel's line-store write to a same-cycle read
  assign a_eff  = fw_a ? fw_prev : q_a[PIXEL_BITS-1:0];
  assign up_eff = fw_a ? fw_old  : q_a[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rt_eff = fw_b ? fw_prev : q_b[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_accept) begin
      s1_vld <= 1'b1;
    end else if (s1_go) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix   <= pixel_value;
      s1_row   <= row;
      s1_col   <= col;
      s1_flags <= flags;
      fw_a     <= s1_go && (col == s1_col);
      fw_b     <= s1_go && (addr_b == s1_col);
      fw_prev  <= s1_pix;
      fw_old   <= a_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_above <= '0;
      recent_pix   <= '0;
      two_back     <= '0;
    end else if (s1_go) begin
      recent_above <= a_eff;
      recent_pix   <= s1_pix;
      two_back     <= recent_pix;
    end
  end

  gldp_eval #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_eval (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .s1_vld      (s1_vld),
    .flags       (s1_flags),
    .row         (s1_row),
    .col         (s1_col),
    .v           (s1_pix),
    .a           (a_eff),
    .up          (up_eff),
    .rt          (rt_eff),
    .lf          (recent_above),
    .p           (recent_pix),
    .pl          (two_back),
    .s1_go       (s1_go),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .peak_value  (peak_value),
    .peak_row    (peak_row),
    .peak_column (peak_column),
    .peak_index  (peak_index),
    .last_of_run (last_of_run)
  );

endmodule

### design/gldp_ram.sv
module gldp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### design/gldp_ctrl.sv
module gldp_ctrl import gldp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      advance,
  output logic                      restart,
  output logic [ROW_BITS-1:0]       row,
  output logic [COL_W-1:0]          col,
  output pos_flags_t                flags
);

  localparam logic [COL_W-1:0] COL_LAST_RST =
    COL_W'((RESET_WIDTH > MAX_WIDTH ? MAX_WIDTH : RESET_WIDTH) - 1);
  localparam logic [ROW_BITS-1:0] ROW_LAST_RST =
    ROW_BITS'((RESET_HEIGHT > MAX_HEIGHT ? MAX_HEIGHT : RESET_HEIGHT) - 1);

  logic [COL_W-1:0]       col_last;
  logic [ROW_BITS-1:0]    row_last;
  logic [COL_W-1:0]       col_last_next;
  logic [ROW_BITS-1:0]    row_last_next;
  logic [WIDTH_BITS-1:0]  w_in;
  logic [HEIGHT_BITS-1:0] h_in;
  logic                   wr_width;
  logic                   wr_height;

  assign w_in      = cfg_data[WIDTH_BITS-1:0];
  assign h_in      = cfg_data[HEIGHT_BITS-1:0];
  assign wr_width  = cfg_write && (cfg_index == REG_FRAME_WIDTH);
  assign wr_height = cfg_write && (cfg_index == REG_FRAME_HEIGHT);
  assign restart   = wr_width || wr_height;

  always_comb begin
    if (w_in == '0) begin
      col_last_next = '0;
    end else if (32'(w_in) > MAX_WIDTH) begin
      col_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last_next = COL_W'(w_in - 1'b1);
    end
    if (h_in == '0) begin
      row_last_next = '0;
    end else if (h_in > HEIGHT_BITS'(MAX_HEIGHT)) begin
      row_last_next = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      row_last_next = ROW_BITS'(h_in - 1'b1);
    end
  end

  always_comb begin
    flags.col_first = (col == '0);
    flags.col_ge2   = ({1'b0, col} >= (COL_W+1)'(2));
    flags.last_col  = (col == col_last);
    flags.row_ge1   = (row != '0);
    flags.row_ge2   = (row[ROW_BITS-1:1] != '0);
    flags.last_row  = (row == row_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= COL_LAST_RST;
      row_last <= ROW_LAST_RST;
      row      <= '0;
      col      <= '0;
    end else if (restart) begin
      if (wr_width) begin
        col_last <= col_last_next;
      end
      if (wr_height) begin
        row_last <= row_last_next;
      end
      row <= '0;
      col <= '0;
    end else if (advance) begin
      if (flags.last_col) begin
        col <= '0;
        row <= flags.last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

### design/gldp_eval.sv
module gldp_eval import gldp_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  logic                    s1_vld,
  input  pos_flags_t              flags,
  input  logic [ROW_BITS-1:0]     row,
  input  logic [COL_W-1:0]        col,
  input  logic [PIXEL_BITS-1:0]   v,
  input  logic [PIXEL_BITS-1:0]   a,
  input  logic [PIXEL_BITS-1:0]   up,
  input  logic [PIXEL_BITS-1:0]   rt,
  input  logic [PIXEL_BITS-1:0]   lf,
  input  logic [PIXEL_BITS-1:0]   p,
  input  logic [PIXEL_BITS-1:0]   pl,
  output logic                    s1_go,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIXEL_BITS-1:0]   peak_value,
  output logic [ROW_BITS-1:0]     peak_row,
  output logic [COL_OUT_BITS-1:0] peak_column,
  output logic [INDEX_BITS-1:0]   peak_index,
  output logic                    last_of_run
);

  function automatic logic [INDEX_BITS-1:0] sat_add(logic [INDEX_BITS-1:0] x, logic [1:0] k);
    logic [INDEX_BITS:0] s;
    s = {1'b0, x} + (INDEX_BITS+1)'(k);
    return s[INDEX_BITS] ? '1 : s[INDEX_BITS-1:0];
  endfunction

  logic [INDEX_BITS-1:0] pc;
  logic [2:0]            res_vld;
  logic [PIXEL_BITS-1:0] res_val [3];
  logic [ROW_BITS-1:0]   res_row [3];
  logic [COL_W-1:0]      res_col [3];
  logic [INDEX_BITS-1:0] res_idx [3];

  logic       e_a, e_b, e_c;
  logic [2:0] sel;
  logic [2:0] take;
  logic       out_accept;
  logic       res_free;
  logic [1:0] n_ab;
  logic [1:0] n_all;

  assign e_a = flags.row_ge1 && (a > v) && (!flags.row_ge2 || a > up) &&
               (flags.col_first || a > lf) && (flags.last_col || a > rt);
  assign e_b = flags.last_row && !flags.col_first && (p > v) &&
               (!flags.col_ge2 || p > pl) && (!flags.row_ge1 || p > lf);
  assign e_c = flags.last_row && flags.last_col && (flags.col_first || v > p) &&
               (!flags.row_ge1 || v > a);

  assign n_ab  = 2'(e_a) + 2'(e_b);
  assign n_all = n_ab + 2'(e_c);

  assign sel[0] = res_vld[0];
  assign sel[1] = res_vld[1] && !res_vld[0];
  assign sel[2] = res_vld[2] && !res_vld[1] && !res_vld[0];

  assign out_valid  = |res_vld;
  assign out_accept = out_valid && !out_stall;
  assign take       = out_accept ? sel : 3'b000;
  assign res_free   = ((res_vld & ~take) == 3'b000);
  assign s1_go      = s1_vld && res_free;
  assign last_of_run = ((res_vld & ~sel) == 3'b000);

  always_comb begin
    priority if (sel[0]) begin
      peak_value  = res_val[0];
      peak_row    = res_row[0];
      peak_column = COL_OUT_BITS'(res_col[0]);
      peak_index  = res_idx[0];
    end else if (sel[1]) begin
      peak_value  = res_val[1];
      peak_row    = res_row[1];
      peak_column = COL_OUT_BITS'(res_col[1]);
      peak_index  = res_idx[1];
    end else begin
      peak_value  = res_val[2];
      peak_row    = res_row[2];
      peak_column = COL_OUT_BITS'(res_col[2]);
      peak_index  = res_idx[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= '0;
      pc      <= '0;
    end else if (restart) begin
      pc <= '0;
    end else if (s1_go) begin
      res_vld <= {e_c, e_b, e_a};
      pc      <= (flags.last_row && flags.last_col) ? '0 : sat_add(pc, n_all);
    end else begin
      res_vld <= res_vld & ~take;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_val[0] <= a;
      res_row[0] <= row - 1'b1;
      res_col[0] <= col;
      res_idx[0] <= pc;
      res_val[1] <= p;
      res_row[1] <= row;
      res_col[1] <= col - 1'b1;
      res_idx[1] <= sat_add(pc, {1'b0, e_a});
      res_val[2] <= v;
      res_row[2] <= row;
      res_col[2] <= col;
      res_idx[2] <= sat_add(pc, n_ab);
    end
  end

endmodule
